@@ src/qsc_pkg.sv @@
// Shared constants for the quadrature step counter.
package qsc_pkg;

  localparam int COUNT_MAX = 1023;
  localparam int CNT_W     = $clog2(COUNT_MAX + 1);
  // Room for the count plus or minus two steps of at most four, with sign.
  localparam int SUM_W     = CNT_W + 2;

  localparam int BTN_W     = 3;
  localparam int ENC_W     = 4;
  localparam int COUNT_W   = 10;
  localparam int MODE_W    = 3;
  localparam int PHASE_W   = 2;
  localparam int STEP_W    = 3;

  localparam int HIST_W    = 16;
  localparam logic [HIST_W-1:0] DB_FORCE = 16'hE000;
  localparam logic [HIST_W-1:0] DB_FIRE  = 16'hF000;

  localparam logic [PHASE_W-1:0] PH_UP   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DOWN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_HOME = 2'd3;

  localparam logic [1:0] SEL_NONE = 2'd3;

endpackage

@@ src/qsc_if.sv @@
// Handshake channels for the sample word and the result word.
interface qsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [qsc_pkg::BTN_W-1:0]    button_levels;
  logic [qsc_pkg::ENC_W-1:0]    encoder_bits;

  modport source(output valid, button_levels, encoder_bits, input ready);
  modport sink(input valid, button_levels, encoder_bits, output ready);
endinterface

interface qsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [qsc_pkg::COUNT_W-1:0]  count_value;
  logic [qsc_pkg::MODE_W-1:0]   mode_bits;

  modport source(output valid, count_value, mode_bits, input ready);
  modport sink(input valid, count_value, mode_bits, output ready);
endinterface

@@ src/qsc_mode.sv @@
// Button debounce histories and the step/hex mode register.
module qsc_mode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [qsc_pkg::BTN_W-1:0]   buttons,
  output logic [qsc_pkg::MODE_W-1:0]  mode_nxt
);

  logic [qsc_pkg::HIST_W-1:0] hist_r   [qsc_pkg::BTN_W];
  logic [qsc_pkg::HIST_W-1:0] hist_nxt [qsc_pkg::BTN_W];
  logic [qsc_pkg::MODE_W-1:0] mode_r;
  logic [qsc_pkg::BTN_W-1:0]  fire;

  always_comb begin
    for (int i = 0; i < qsc_pkg::BTN_W; i++) begin
      hist_nxt[i] = {hist_r[i][qsc_pkg::HIST_W-2:0], buttons[i]} | qsc_pkg::DB_FORCE;
      fire[i]     = (hist_nxt[i] == qsc_pkg::DB_FIRE);
    end
    // each pulse toggles its own mode bit
    mode_nxt = mode_r ^ fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qsc_pkg::BTN_W; i++) begin
        hist_r[i] <= '0;
      end
      mode_r <= '0;
    end else if (adv) begin
      hist_r <= hist_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

@@ src/qsc_count.sv @@
// Encoder phase tracking and the wrapping step counter.
module qsc_count (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [qsc_pkg::ENC_W-1:0]    encoders,
  input  logic [qsc_pkg::MODE_W-1:0]   mode,
  output logic [qsc_pkg::CNT_W-1:0]    count_nxt
);

  logic [qsc_pkg::PHASE_W-1:0]       left_prev_r;
  logic [qsc_pkg::PHASE_W-1:0]       right_prev_r;
  logic [qsc_pkg::CNT_W-1:0]         count_r;
  logic [qsc_pkg::PHASE_W-1:0]       left_now;
  logic [qsc_pkg::PHASE_W-1:0]       right_now;
  logic [qsc_pkg::STEP_W-1:0]        step;
  logic signed [qsc_pkg::SUM_W-1:0]  step_s;
  logic signed [qsc_pkg::SUM_W-1:0]  d_left;
  logic signed [qsc_pkg::SUM_W-1:0]  d_right;
  logic signed [qsc_pkg::SUM_W-1:0]  sum;

  function automatic logic signed [qsc_pkg::SUM_W-1:0] phase_delta(
    input logic [qsc_pkg::PHASE_W-1:0]      prev,
    input logic [qsc_pkg::PHASE_W-1:0]      now,
    input logic signed [qsc_pkg::SUM_W-1:0] stp
  );
    logic signed [qsc_pkg::SUM_W-1:0] d;
    d = '0;
    if (now == qsc_pkg::PH_HOME && prev == qsc_pkg::PH_UP) begin
      d = stp;
    end else if (now == qsc_pkg::PH_HOME && prev == qsc_pkg::PH_DOWN) begin
      d = -stp;
    end
    return d;
  endfunction

  always_comb begin
    left_now  = encoders[qsc_pkg::PHASE_W-1:0];
    right_now = encoders[qsc_pkg::ENC_W-1:qsc_pkg::PHASE_W];

    // step of 1, 2 or 4; none when both select bits are set
    if (mode[1:0] == qsc_pkg::SEL_NONE) begin
      step = '0;
    end else begin
      step = qsc_pkg::STEP_W'(1) << mode[1:0];
    end
    step_s  = $signed(qsc_pkg::SUM_W'(step));

    d_right = phase_delta(right_prev_r, right_now, step_s);
    d_left  = phase_delta(left_prev_r, left_now, step_s);
    sum     = $signed(qsc_pkg::SUM_W'(count_r)) + d_right + d_left;

    // wrap: past the top lands on one, below zero lands on the top
    if (sum > $signed(qsc_pkg::SUM_W'(qsc_pkg::COUNT_MAX))) begin
      count_nxt = qsc_pkg::CNT_W'(1);
    end else if (sum < 0) begin
      count_nxt = qsc_pkg::CNT_W'(qsc_pkg::COUNT_MAX);
    end else begin
      count_nxt = sum[qsc_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_prev_r  <= '0;
      right_prev_r <= '0;
      count_r      <= '0;
    end else if (adv) begin
      left_prev_r  <= left_now;
      right_prev_r <= right_now;
      count_r      <= count_nxt;
    end
  end

endmodule

@@ src/quadrature_step_counter_top.sv @@
// Top level of the quadrature step counter: sample register, update logic, result register.
//
// Each sample word carries three button levels (high while pressed) and two
// 2-bit encoder phases. Every word produces exactly one result word holding
// the running count (low 10 bits) and the mode bits: bits 1:0 step select,
// bit 2 hex display mode. Buttons are debounced with a 16-bit history each;
// a debounced release of button 0 or 1 toggles a step-select bit, button 2
// toggles hex mode. The step is 1, 2 or 4, and zero when both select bits are
// set. An encoder moving from phase 1 to 3 adds the step, from 2 to 3
// subtracts it; the count then wraps to 1 above the maximum and to the maximum
// below zero. Timing: a word is registered on acceptance, the whole update runs
// from the sample register into the result register, and one word is taken every
// cycle as long as the result side keeps taking words. The result register and
// the sample register each hold one word, so a stalled result holds back the
// input only once both are full.
module quadrature_step_counter_top (
  input  logic       clk,
  input  logic       rst_n,
  qsc_in_if.sink     in_if,
  qsc_out_if.source  out_if
);

  logic                        in_valid_r;
  logic [qsc_pkg::BTN_W-1:0]   btn_r;
  logic [qsc_pkg::ENC_W-1:0]   enc_r;
  logic                        out_valid_r;
  logic [qsc_pkg::COUNT_W-1:0] count_out_r;
  logic [qsc_pkg::MODE_W-1:0]  mode_out_r;

  logic                        out_free;
  logic                        adv;
  logic [qsc_pkg::MODE_W-1:0]  mode_nxt;
  logic [qsc_pkg::CNT_W-1:0]   count_nxt;
  logic [qsc_pkg::CNT_W+qsc_pkg::COUNT_W-1:0] count_ext;

  // Result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_if.ready;
  // Advance the held sample into the result register; this also commits state.
  assign adv      = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || out_free;

  qsc_mode u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .buttons  (btn_r),
    .mode_nxt (mode_nxt)
  );

  qsc_count u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .encoders  (enc_r),
    .mode      (mode_nxt),
    .count_nxt (count_nxt)
  );

  // Output carries only the low 10 bits of the count.
  assign count_ext = (qsc_pkg::CNT_W + qsc_pkg::COUNT_W)'(count_nxt);

  // Sample register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      btn_r <= in_if.button_levels;
      enc_r <= in_if.encoder_bits;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      count_out_r <= count_ext[qsc_pkg::COUNT_W-1:0];
      mode_out_r  <= mode_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.count_value = count_out_r;
  assign out_if.mode_bits   = mode_out_r;

endmodule
